/* design/ovls_pkg.sv */
// shared types and codes of the ordered value list store
`default_nettype none
package ovls_pkg;

	// request codes
	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_DELETE = 2'd1,
		OP_SEARCH = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	// control states
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_WALK = 1'b1
	} state_t;

	// one request transfer
	typedef struct packed {
		op_t                req_type;
		logic signed [31:0] value;
	} req_t;

	// one result transfer
	typedef struct packed {
		logic               found;
		logic [6:0]         stored_count;
		logic               is_empty;
		logic signed [31:0] head_value;
		logic signed [31:0] tail_value;
		logic               full_error;
	} res_t;

endpackage
`default_nettype wire

/* design/ovls_ram.sv */
// generic simple dual-port ram with registered read
`default_nettype none
module ovls_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic                                     re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

/* design/ordered_value_list_store_unit.sv */
// top level of the ordered value list store
//
// Holds up to CAPACITY signed 32-bit values in insertion order in one memory.
// A request is taken when start is high and busy is low; its result shows on
// res for exactly one cycle with done high and cannot be held off. Append,
// clear, and any request on an empty store give their result in the cycle
// after the transfer and leave busy low. Search and delete walk the stored
// entries through the memory's single read port, one entry per cycle, and
// compaction writes kept entries back through the write port in the same
// walk; their result comes after the walk ends, with busy high in between.
// Head and tail values live in registers, so results never wait on an extra
// read.
`default_nettype none
module ordered_value_list_store_unit
	import ovls_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire req_t req,
	output logic      done,
	output res_t      res
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	state_t          state_q, state_d;
	op_t             op_q;
	logic [31:0]     val_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   rd_q;
	logic [CW-1:0]   wr_q;
	logic            pend_s1;
	logic            found_q;
	logic [31:0]     head_q;
	logic [31:0]     tail_q;
	logic            done_q;
	res_t            res_q;

	logic            accept;
	logic            full;
	logic            quick;
	logic            issue;
	logic            keep;
	logic            finish;
	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [31:0]     ram_wdata;
	logic [31:0]     ram_rdata;

	function automatic res_t make_res(input logic fnd, input logic [CW-1:0] cnt,
			input logic [31:0] hd, input logic [31:0] tl, input logic ful);
		res_t r;
		r.found        = fnd;
		r.stored_count = 7'(cnt);
		r.is_empty     = (cnt == '0);
		r.head_value   = (cnt == '0) ? 32'sd0 : $signed(hd);
		r.tail_value   = (cnt == '0) ? 32'sd0 : $signed(tl);
		r.full_error   = ful;
		return r;
	endfunction

	// request decode
	assign accept = start && (state_q == ST_IDLE);
	assign full   = (count_q == CW'(CAPACITY));
	assign quick  = (req.req_type == OP_APPEND) || (req.req_type == OP_CLEAR) ||
		(count_q == '0);

	// walk control
	assign issue  = (state_q == ST_WALK) && (rd_q != count_q);
	assign keep   = pend_s1 && (ram_rdata != val_q);
	assign finish = (state_q == ST_WALK) && !issue && !pend_s1;

	// next state and handshake outputs
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && !quick) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (finish) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign res  = res_q;

	// memory write: append in idle, compaction during a delete walk
	always_comb begin
		if (state_q == ST_WALK) begin
			ram_we    = (op_q == OP_DELETE) && keep;
			ram_waddr = wr_q[AW-1:0];
			ram_wdata = ram_rdata;
		end else begin
			ram_we    = accept && (req.req_type == OP_APPEND) && !full;
			ram_waddr = count_q[AW-1:0];
			ram_wdata = req.value;
		end
	end

	ovls_ram #(
		.WIDTH(32),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (issue),
		.raddr(rd_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			pend_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= issue;
			done_q  <= (accept && quick) || finish;
			if (accept && (req.req_type == OP_APPEND) && !full) begin
				count_q <= count_q + 1'b1;
			end else if (accept && (req.req_type == OP_CLEAR)) begin
				count_q <= '0;
			end else if (finish && (op_q == OP_DELETE)) begin
				count_q <= wr_q;
			end
		end
	end

	// walk datapath, head and tail, result register
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= req.req_type;
			val_q   <= req.value;
			rd_q    <= '0;
			wr_q    <= '0;
			found_q <= 1'b0;
		end else begin
			if (issue) begin
				rd_q <= rd_q + 1'b1;
			end
			if (pend_s1 && !keep) begin
				found_q <= 1'b1;
			end
			if ((op_q == OP_DELETE) && keep) begin
				wr_q   <= wr_q + 1'b1;
				tail_q <= ram_rdata;
				if (wr_q == '0) begin
					head_q <= ram_rdata;
				end
			end
		end
		if (accept && (req.req_type == OP_APPEND) && !full) begin
			tail_q <= req.value;
			if (count_q == '0) begin
				head_q <= req.value;
			end
		end
		// results of requests that are answered without a walk
		if (accept && quick) begin
			case (req.req_type)
				OP_APPEND: res_q <= full ? make_res(1'b0, count_q, head_q, tail_q, 1'b1) :
					make_res(1'b0, count_q + 1'b1,
						(count_q == '0) ? req.value : head_q, req.value, 1'b0);
				OP_CLEAR:  res_q <= make_res(1'b0, '0, head_q, tail_q, 1'b0);
				default:   res_q <= make_res(1'b0, count_q, head_q, tail_q, 1'b0);
			endcase
		end else if (finish) begin
			if (op_q == OP_DELETE) begin
				res_q <= make_res(1'b0, wr_q, head_q, tail_q, 1'b0);
			end else begin
				res_q <= make_res(found_q, count_q, head_q, tail_q, 1'b0);
			end
		end
	end

endmodule
`default_nettype wire

/* design/ovls_chk.sv */
// port-level checker for the ordered value list store, bound to the top level
`default_nettype none
module ovls_chk
	import ovls_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire res_t res
);

	// an empty store reports zero count, head and tail
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.is_empty |->
			res.stored_count == 7'd0 && res.head_value == 32'sd0 && res.tail_value == 32'sd0)
		else $error("empty result carries nonzero count, head or tail");

	// a found value implies a nonempty store and no full error
	a_found_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.found |-> !res.is_empty && !res.full_error)
		else $error("found flag with empty store or full error");

	// every transfer either answers next cycle or holds busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done || busy)
		else $error("accepted request neither answered nor busy");

	// the end of a walk always delivers a result
	a_walk_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	// no result appears while a walk is still running
	a_busy_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		busy && $past(busy) |-> !done)
		else $error("result during a walk");

endmodule

bind ordered_value_list_store_unit ovls_chk u_ovls_chk (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.res   (res)
);
`default_nettype wire
